[src/sle_pkg.sv]
// Shared constants for the sorted list engine: sizes, operation and status codes.
package sle_pkg;

  // Table size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Fixed result field widths
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

[src/sle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sorted_list_engine.sv]
// Top level of the sorted list engine: sequencer, compare unit and table memory.
//
//  Channel   Ports                               Handshake
//  --------  ----------------------------------  ------------------------------
//  request   start, op, value                    taken when start & !busy
//  result    done, status, position, entry_count done high for one cycle
//
// One request walks the table once, one entry a cycle, through the single
// read port of the table memory and one shared compare unit. Insert walks
// the held entries plus one slot past the end, search and remove walk the
// held entries; a full insert, an empty search or remove and the
// unused opcode answer without a walk. Reset empties the table at once. The
// result cannot be held off; the next request may start in the cycle it shows.
module sorted_list_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic signed [sle_pkg::DATA_W-1:0] value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [sle_pkg::POS_W-1:0]         position,
  output logic [sle_pkg::COUNT_W-1:0]       entry_count
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                        state;
  logic [1:0]                    cur_op;
  logic signed [sle_pkg::DATA_W-1:0] cur_val;
  logic [sle_pkg::CNT_W-1:0]     count;
  logic [sle_pkg::CNT_W-1:0]     count_next;
  logic [sle_pkg::CNT_W-1:0]     rd_idx;
  logic [sle_pkg::CNT_W-1:0]     last;
  logic                          issuing;
  logic                          p_valid;
  logic [sle_pkg::CNT_W-1:0]     p_idx;
  logic                          hit;
  logic [sle_pkg::IDX_W-1:0]     hit_pos;
  logic [sle_pkg::DATA_W-1:0]    carry;

  logic                          we;
  logic [sle_pkg::IDX_W-1:0]     waddr;
  logic [sle_pkg::DATA_W-1:0]    wdata;
  logic [sle_pkg::DATA_W-1:0]    rdata;
  logic                          hit_now;
  logic                          final_hit;
  logic [sle_pkg::IDX_W-1:0]     final_pos;
  logic                          accept;
  logic                          quick;
  logic                          finish;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign finish = p_valid && (p_idx == last);

  // Answer at once when no walk is needed
  always_comb begin
    quick = 1'b0;
    if (op == sle_pkg::OP_INSERT) begin
      quick = (count == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
    end else if (op == sle_pkg::OP_SEARCH || op == sle_pkg::OP_REMOVE) begin
      quick = (count == '0);
    end else begin
      quick = 1'b1;
    end
  end

  // Compare the returned entry and steer the write port
  always_comb begin
    hit_now = 1'b0;
    we      = 1'b0;
    waddr   = p_idx[sle_pkg::IDX_W-1:0];
    wdata   = carry;
    if (p_valid) begin
      unique case (cur_op)
        sle_pkg::OP_INSERT: begin
          if (hit) begin
            we    = 1'b1;
            wdata = carry;
          end else if (p_idx == count || !($signed(rdata) < cur_val)) begin
            hit_now = 1'b1;
            we      = 1'b1;
            wdata   = cur_val;
          end
        end
        sle_pkg::OP_REMOVE: begin
          if (hit) begin
            we    = 1'b1;
            waddr = sle_pkg::IDX_W'(p_idx - 1'b1);
            wdata = rdata;
          end else if (rdata == cur_val) begin
            hit_now = 1'b1;
          end
        end
        default: begin
          hit_now = !hit && (rdata == cur_val);
        end
      endcase
    end
  end

  assign final_hit = hit || hit_now;
  assign final_pos = hit ? hit_pos : p_idx[sle_pkg::IDX_W-1:0];

  // Count after the walk
  always_comb begin
    count_next = count;
    if (cur_op == sle_pkg::OP_INSERT) begin
      count_next = count + 1'b1;
    end else if (cur_op == sle_pkg::OP_REMOVE && final_hit) begin
      count_next = count - 1'b1;
    end
  end

  // Sequencer, walk pipeline and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issuing <= 1'b0;
      p_valid <= 1'b0;
      hit     <= 1'b0;
      done    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= accept && quick;
          if (accept) begin
            cur_op  <= op;
            cur_val <= value;
            if (quick) begin
              status      <= (op == sle_pkg::OP_INSERT) ? sle_pkg::ST_FULL
                                                        : sle_pkg::ST_NOT_FOUND;
              position    <= '0;
              entry_count <= sle_pkg::COUNT_W'(count);
            end else begin
              state   <= S_SCAN;
              rd_idx  <= '0;
              issuing <= 1'b1;
              p_valid <= 1'b0;
              hit     <= 1'b0;
              last    <= (op == sle_pkg::OP_INSERT) ? count : count - 1'b1;
            end
          end
        end
        S_SCAN: begin
          done <= finish;
          // Advance the read address
          if (issuing) begin
            p_valid <= 1'b1;
            p_idx   <= rd_idx;
            if (rd_idx == last) begin
              issuing <= 1'b0;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end else begin
            p_valid <= 1'b0;
          end
          // Hold the displaced entry and the match position
          if (p_valid) begin
            carry <= rdata;
            if (hit_now) begin
              hit     <= 1'b1;
              hit_pos <= p_idx[sle_pkg::IDX_W-1:0];
            end
          end
          // Drop out with the result after the last entry
          if (finish) begin
            state       <= S_IDLE;
            count       <= count_next;
            status      <= final_hit ? sle_pkg::ST_DONE : sle_pkg::ST_NOT_FOUND;
            position    <= final_hit ? sle_pkg::POS_W'(final_pos) : '0;
            entry_count <= sle_pkg::COUNT_W'(count_next);
          end
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Table storage
  sle_ram #(
    .WIDTH(sle_pkg::DATA_W),
    .DEPTH(sle_pkg::CAPACITY)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx[sle_pkg::IDX_W-1:0]),
    .rdata(rdata)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the sorted list engine: insert, search and remove requests.
`timescale 1ns / 100ps

module tb_top;

  // Opcode the engine answers without touching the table
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 80;
  localparam int NUM_ITEMS    = 850;

  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]                  status;
    logic [sle_pkg::POS_W-1:0]   position;
    logic [sle_pkg::COUNT_W-1:0] entry_count;
  } outcome_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  // Mirror of the table; predicts one outcome per accepted request
  class sorted_table_scoreboard;
    logic signed [sle_pkg::DATA_W-1:0] entries_m [sle_pkg::CAPACITY];
    int                                held;
    outcome_t                          pending_outcomes [$];
    int                                failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int find_first(logic signed [sle_pkg::DATA_W-1:0] v);
      for (int i = 0; i < held; i++) begin
        if (entries_m[i] == v) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] req_op, logic signed [sle_pkg::DATA_W-1:0] v);
      outcome_t exp;
      int       i;
      exp.status   = sle_pkg::ST_NOT_FOUND;
      exp.position = '0;
      if (req_op == sle_pkg::OP_INSERT) begin
        if (held >= sle_pkg::CAPACITY) begin
          exp.status = sle_pkg::ST_FULL;
        end else begin
          // place ahead of the first entry that is not smaller
          i = 0;
          while (i < held && entries_m[i] < v) i++;
          for (int j = held; j > i; j--) entries_m[j] = entries_m[j-1];
          entries_m[i] = v;
          held++;
          exp.status   = sle_pkg::ST_DONE;
          exp.position = sle_pkg::POS_W'(i);
        end
      end else if (req_op == sle_pkg::OP_SEARCH) begin
        i = find_first(v);
        if (i >= 0) begin
          exp.status   = sle_pkg::ST_DONE;
          exp.position = sle_pkg::POS_W'(i);
        end
      end else if (req_op == sle_pkg::OP_REMOVE) begin
        i = find_first(v);
        if (i >= 0) begin
          // close the gap left by the removed entry
          for (int j = i; j < held - 1; j++) entries_m[j] = entries_m[j+1];
          held--;
          exp.status   = sle_pkg::ST_DONE;
          exp.position = sle_pkg::POS_W'(i);
        end
      end
      exp.entry_count = sle_pkg::COUNT_W'(held);
      pending_outcomes.push_back(exp);
    endfunction

    function void check_result(logic [1:0] st, logic [sle_pkg::POS_W-1:0] pos,
                               logic [sle_pkg::COUNT_W-1:0] cnt);
      outcome_t exp;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request pending: status %0d position %0d entry_count %0d",
               st, pos, cnt);
        failures++;
        return;
      end
      exp = pending_outcomes.pop_front();
      if (st !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, st);
        failures++;
      end
      if (pos !== exp.position) begin
        $error("position: expected %0d, actual %0d", exp.position, pos);
        failures++;
      end
      if (cnt !== exp.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", exp.entry_count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [1:0]                        op;
  logic signed [sle_pkg::DATA_W-1:0] value;
  logic                              done;
  logic [1:0]                        status;
  logic [sle_pkg::POS_W-1:0]         position;
  logic [sle_pkg::COUNT_W-1:0]       entry_count;

  sorted_table_scoreboard sb;
  int                     sent;

  sorted_list_engine uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .value       (value),
    .done        (done),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every result strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, position, entry_count);
  end

  // Watchdog: end the run after too many cycles without any handshake
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Issue one request after an idle gap and hold it until taken
  task automatic send_request(input logic [1:0] req_op,
                              input logic signed [sle_pkg::DATA_W-1:0] req_value,
                              input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    op    <= req_op;
    value <= req_value;
    do @(posedge clk); while (busy);
    sb.note_request(req_op, req_value);
    sent++;
  endtask

  // Nearly half a narrow band to force duplicates, some extremes, the rest full range
  function automatic logic signed [sle_pkg::DATA_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return int'($urandom_range(0, 23)) - 12;
    if (r < 60) begin
      case ($urandom_range(0, 4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -1;
        3: return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $urandom();
  endfunction

  // Prefer a value that is present so searches and removes hit
  function automatic logic signed [sle_pkg::DATA_W-1:0] lookup_value();
    if (sb.held > 0 && $urandom_range(0, 99) < 70)
      return sb.entries_m[$urandom_range(0, sb.held - 1)];
    return random_value();
  endfunction

  task automatic run_phase(input phase_t mode, input int n_items, input bit no_idle);
    int          ins_pct;
    int          rem_pct;
    int unsigned r;
    int          gap;
    case (mode)
      PH_FILL:  begin ins_pct = 80; rem_pct = 8;  end
      PH_DRAIN: begin ins_pct = 12; rem_pct = 70; end
      default:  begin ins_pct = 40; rem_pct = 30; end
    endcase
    repeat (n_items) begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      r   = $urandom_range(0, 99);
      if (r < 3)
        send_request(OP_UNUSED, random_value(), gap);
      else if (r < 3 + ins_pct)
        send_request(sle_pkg::OP_INSERT, random_value(), gap);
      else if (r < 3 + ins_pct + rem_pct)
        send_request(sle_pkg::OP_REMOVE, lookup_value(), gap);
      else
        send_request(sle_pkg::OP_SEARCH, lookup_value(), gap);
    end
  endtask

  initial begin : stimulus
    phase_t mode;
    int     len;
    sb    = new();
    sent  = 0;
    rst   = 1'b1;
    start = 1'b0;
    op    = sle_pkg::OP_INSERT;
    value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, only entry, extremes, duplicates, misses
    send_request(sle_pkg::OP_SEARCH, 0, 0);
    send_request(sle_pkg::OP_REMOVE, 5, 1);
    send_request(OP_UNUSED, VAL_MAX, 0);
    send_request(sle_pkg::OP_INSERT, 0, 0);
    send_request(sle_pkg::OP_REMOVE, 0, 0);
    send_request(sle_pkg::OP_INSERT, VAL_MAX, 2);
    send_request(sle_pkg::OP_INSERT, VAL_MIN, 0);
    send_request(sle_pkg::OP_INSERT, 0, 0);
    send_request(sle_pkg::OP_INSERT, 0, 3);
    send_request(sle_pkg::OP_INSERT, -1, 0);
    send_request(sle_pkg::OP_INSERT, 1, 0);
    send_request(sle_pkg::OP_INSERT, 32'sh5555_5555, 0);
    send_request(sle_pkg::OP_INSERT, 32'shaaaa_aaaa, 4);
    send_request(sle_pkg::OP_SEARCH, VAL_MIN, 0);
    send_request(sle_pkg::OP_SEARCH, VAL_MAX, 0);
    send_request(sle_pkg::OP_SEARCH, 0, 1);
    send_request(sle_pkg::OP_SEARCH, 7, 0);
    send_request(sle_pkg::OP_REMOVE, 0, 0);
    send_request(sle_pkg::OP_REMOVE, 7, 0);
    send_request(OP_UNUSED, VAL_MIN, 0);
    send_request(sle_pkg::OP_REMOVE, VAL_MAX, 2);
    send_request(sle_pkg::OP_REMOVE, VAL_MIN, 0);
    send_request(sle_pkg::OP_SEARCH, 32'shaaaa_aaaa, 0);

    // Random: fill-heavy, drain-heavy and mixed phases, picked at random
    while (sent < NUM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       begin mode = PH_FILL;  len = 100; end
        1:       begin mode = PH_DRAIN; len = 100; end
        default: begin mode = PH_MIXED; len = 60;  end
      endcase
      // Stop at the planned request total
      if (len > NUM_ITEMS - sent) len = NUM_ITEMS - sent;
      run_phase(mode, len, $urandom_range(0, 3) == 0);
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes
    while (sb.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending_outcomes.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
